// ===== src/priority_budget_slot_picker_defines.svh =====
// Assertion helpers shared by the slot picker modules.
`ifndef PRIORITY_BUDGET_SLOT_PICKER_DEFINES_SVH
`define PRIORITY_BUDGET_SLOT_PICKER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define PBSP_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition is followed by a result in the next cycle.
`define PBSP_ASSERT_NEXT(name, cond, res, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (res)) else $error(msg);

`endif

// ===== src/pbsp_pkg.sv =====
`timescale 1ns / 1ps

package pbsp_pkg;

   localparam int PRIO_W    = 8;
   localparam int BUDGET_W  = 8;
   localparam int INDEX_W   = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 8;
   localparam int ENTRY_W   = 1 + PRIO_W + BUDGET_W;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRIO_LOW      = 3'd0,
      CSR_PRIO_NORMAL   = 3'd1,
      CSR_PRIO_HIGH     = 3'd2,
      CSR_BUDGET_LOW    = 3'd3,
      CSR_BUDGET_NORMAL = 3'd4,
      CSR_BUDGET_HIGH   = 3'd5
   } csr_index_type;

   // Request kinds
   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_PICK  = 1'b1
   } req_kind_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic align_step;
      logic scan_rd;
      logic reload_rd;
      logic slot_write;
      logic finish;
   } pbsp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic align_done;
      logic last_issue;
      logic have;
      logic refilled;
   } pbsp_sts_type;

endpackage

// ===== src/pbsp_channels.sv =====
`timescale 1ns / 1ps

interface pbsp_req_if;
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic [pbsp_pkg::INDEX_W-1:0]  slot_index;
   logic                          is_runnable;
   logic [pbsp_pkg::PRIO_W-1:0]   raw_priority;
   logic [pbsp_pkg::BUDGET_W-1:0] budget_value;

   modport source (output valid, req_type, slot_index, is_runnable, raw_priority,
                   budget_value, input ready);
   modport sink (input valid, req_type, slot_index, is_runnable, raw_priority,
                 budget_value, output ready);
endinterface

interface pbsp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [pbsp_pkg::INDEX_W-1:0] chosen_slot;
   logic                         did_replenish;

   modport source (output valid, found, chosen_slot, did_replenish, input ready);
   modport sink (input valid, found, chosen_slot, did_replenish, output ready);
endinterface

// ===== src/priority_budget_slot_picker.sv =====
`timescale 1ns / 1ps

// Slot picker with round-robin scan and per-slot budgets. A write request
// loads one slot (runnable flag, raw priority, budget) and is answered with
// an all-zero response once the slot has been written. A pick request scans
// the slots one per cycle, starting just after slot_index and wrapping, and
// returns the runnable slot with a nonzero budget and the highest sanitized
// priority, the first one met on ties. If none qualifies, a reload sweep
// refills the budget of every runnable slot from its priority class and the
// scan runs again. The start index is wrapped into range before the scan,
// and the slot memory has a single read port, visited one entry a cycle.
// One request is worked at a time; a new one is taken while the previous
// response still waits on rsp.
module priority_budget_slot_picker #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [pbsp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pbsp_pkg::CSR_W-1:0]     csr_data,
   pbsp_req_if.sink                       req_if,
   pbsp_rsp_if.source                     rsp_if
);

   pbsp_pkg::pbsp_cmd_type cmd;
   pbsp_pkg::pbsp_sts_type sts;

   pbsp_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_is_pick (req_if.req_type == pbsp_pkg::REQ_PICK),
      .req_ready   (req_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .cmd         (cmd),
      .sts         (sts)
   );

   pbsp_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_type      (req_if.req_type),
      .slot_index    (req_if.slot_index),
      .is_runnable   (req_if.is_runnable),
      .raw_priority  (req_if.raw_priority),
      .budget_value  (req_if.budget_value),
      .cmd           (cmd),
      .sts           (sts),
      .found         (rsp_if.found),
      .chosen_slot   (rsp_if.chosen_slot),
      .did_replenish (rsp_if.did_replenish)
   );

endmodule

// ===== src/pbsp_ram.sv =====
`timescale 1ns / 1ps

module pbsp_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pbsp_datapath.sv =====
`timescale 1ns / 1ps
`include "priority_budget_slot_picker_defines.svh"

module pbsp_datapath #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [pbsp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pbsp_pkg::CSR_W-1:0]        csr_data,
   input  logic                              req_type,
   input  logic [pbsp_pkg::INDEX_W-1:0]      slot_index,
   input  logic                              is_runnable,
   input  logic [pbsp_pkg::PRIO_W-1:0]       raw_priority,
   input  logic [pbsp_pkg::BUDGET_W-1:0]     budget_value,
   input  pbsp_pkg::pbsp_cmd_type            cmd,
   output pbsp_pkg::pbsp_sts_type            sts,
   output logic                              found,
   output logic [pbsp_pkg::INDEX_W-1:0]      chosen_slot,
   output logic                              did_replenish
);

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int RW = (SW + 1 > 5) ? SW + 1 : 5;
   localparam logic [RW-1:0] N_R    = RW'(NUM_SLOTS);
   localparam logic [RW-1:0] LAST_R = RW'(NUM_SLOTS - 1);
   localparam logic [SW-1:0] LAST_C = SW'(NUM_SLOTS - 1);

   // Configuration registers
   logic [pbsp_pkg::PRIO_W-1:0]   prio_low_ff, prio_normal_ff, prio_high_ff;
   logic [pbsp_pkg::BUDGET_W-1:0] bud_low_ff, bud_normal_ff, bud_high_ff;

   // Captured request
   logic                          req_type_ff;
   logic [pbsp_pkg::INDEX_W-1:0]  idx_ff;
   logic                          run_ff;
   logic [pbsp_pkg::PRIO_W-1:0]   prio_ff;
   logic [pbsp_pkg::BUDGET_W-1:0] budget_ff;

   // Scan control and results
   logic [RW-1:0]                 pos_ff, pos_in;
   logic [SW-1:0]                 cnt_ff, cnt_in;
   logic                          scan_d_ff, reload_d_ff;
   logic [SW-1:0]                 addr_d_ff;
   logic [NUM_SLOTS-1:0]          valid_ff, valid_in;
   logic                          have_ff, have_in;
   logic [pbsp_pkg::PRIO_W-1:0]   best_ff, best_in;
   logic [SW-1:0]                 pick_ff, pick_in;
   logic                          refill_ff, refill_in;
   logic                          found_ff;
   logic [pbsp_pkg::INDEX_W-1:0]  chosen_ff;
   logic                          replenish_ff;

   // Slot memory
   logic                          wr_en;
   logic [SW-1:0]                 wr_addr;
   logic [pbsp_pkg::ENTRY_W-1:0]  wr_data;
   logic                          rd_en;
   logic [pbsp_pkg::ENTRY_W-1:0]  rd_data;

   logic                          rd_run;
   logic [pbsp_pkg::PRIO_W-1:0]   rd_prio;
   logic [pbsp_pkg::BUDGET_W-1:0] rd_budget;
   logic [pbsp_pkg::PRIO_W-1:0]   rd_clean;
   logic                          entry_live;
   logic                          qualify;
   logic                          reload_wr;
   logic [RW-1:0]                 idx_ext;
   logic                          slot_wr;
   logic                          advance;

   // Map an out-of-range priority onto the normal level
   function automatic logic [pbsp_pkg::PRIO_W-1:0] clean_prio(
      input logic [pbsp_pkg::PRIO_W-1:0] p
   );
      if (p < prio_low_ff || p > prio_high_ff) begin
         return prio_normal_ff;
      end
      return p;
   endfunction

   // Pick the reload budget from the priority class, high tested first
   function automatic logic [pbsp_pkg::BUDGET_W-1:0] reload_amount(
      input logic [pbsp_pkg::PRIO_W-1:0] cp
   );
      if (cp == prio_high_ff) begin
         return bud_high_ff;
      end
      if (cp == prio_normal_ff) begin
         return bud_normal_ff;
      end
      return bud_low_ff;
   endfunction

   pbsp_ram #(
      .WIDTH (pbsp_pkg::ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (pos_ff[SW-1:0]),
      .rd_data (rd_data)
   );

   // Unpack the entry read last cycle
   assign rd_run     = rd_data[pbsp_pkg::ENTRY_W-1];
   assign rd_prio    = rd_data[pbsp_pkg::PRIO_W+pbsp_pkg::BUDGET_W-1:pbsp_pkg::BUDGET_W];
   assign rd_budget  = rd_data[pbsp_pkg::BUDGET_W-1:0];
   assign rd_clean   = clean_prio(rd_prio);
   assign entry_live = valid_ff[addr_d_ff] && rd_run;
   assign qualify    = scan_d_ff && entry_live && (rd_budget != '0);
   assign reload_wr  = reload_d_ff && entry_live;

   // Slot writes beyond the table are dropped
   assign idx_ext = RW'(idx_ff);
   assign slot_wr = cmd.slot_write && (idx_ext < N_R);

   assign rd_en   = cmd.scan_rd || cmd.reload_rd;
   assign advance = rd_en;
   assign wr_en   = slot_wr || reload_wr;
   assign wr_addr = slot_wr ? idx_ext[SW-1:0] : addr_d_ff;
   assign wr_data = slot_wr ? {run_ff, prio_ff, budget_ff}
                            : {1'b1, rd_prio, reload_amount(rd_clean)};

   // Next state of the scan position, counter and best candidate
   always_comb begin
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      valid_in  = valid_ff;
      have_in   = have_ff;
      best_in   = best_ff;
      pick_in   = pick_ff;
      refill_in = refill_ff;
      if (cmd.capture) begin
         pos_in    = RW'(slot_index) + RW'(1);
         cnt_in    = '0;
         have_in   = 1'b0;
         refill_in = 1'b0;
      end
      if (cmd.align_step && !(pos_ff < N_R)) begin
         pos_in = pos_ff - N_R;
      end
      if (advance) begin
         pos_in = (pos_ff == LAST_R) ? '0 : pos_ff + RW'(1);
         cnt_in = (cnt_ff == LAST_C) ? '0 : cnt_ff + SW'(1);
      end
      if (cmd.reload_rd) begin
         refill_in = 1'b1;
      end
      if (slot_wr) begin
         valid_in[idx_ext[SW-1:0]] = 1'b1;
      end
      if (qualify && (!have_ff || rd_clean > best_ff)) begin
         have_in = 1'b1;
         best_in = rd_clean;
         pick_in = addr_d_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         cnt_ff      <= '0;
         scan_d_ff   <= 1'b0;
         reload_d_ff <= 1'b0;
         valid_ff    <= '0;
         have_ff     <= 1'b0;
         refill_ff   <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         cnt_ff      <= cnt_in;
         scan_d_ff   <= cmd.scan_rd;
         reload_d_ff <= cmd.reload_rd;
         valid_ff    <= valid_in;
         have_ff     <= have_in;
         refill_ff   <= refill_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_d_ff <= pos_ff[SW-1:0];
      best_ff   <= best_in;
      pick_ff   <= pick_in;
      if (cmd.capture) begin
         req_type_ff <= req_type;
         idx_ff      <= slot_index;
         run_ff      <= is_runnable;
         prio_ff     <= raw_priority;
         budget_ff   <= budget_value;
      end
      if (cmd.finish) begin
         found_ff     <= have_ff && (req_type_ff == pbsp_pkg::REQ_PICK);
         chosen_ff    <= have_ff ? pbsp_pkg::INDEX_W'(RW'(pick_ff)) : '0;
         replenish_ff <= refill_ff;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prio_low_ff    <= 8'd0;
         prio_normal_ff <= 8'd1;
         prio_high_ff   <= 8'd2;
         bud_low_ff     <= 8'd1;
         bud_normal_ff  <= 8'd2;
         bud_high_ff    <= 8'd4;
      end else if (csr_write) begin
         case (csr_index)
            pbsp_pkg::CSR_PRIO_LOW:      prio_low_ff    <= csr_data;
            pbsp_pkg::CSR_PRIO_NORMAL:   prio_normal_ff <= csr_data;
            pbsp_pkg::CSR_PRIO_HIGH:     prio_high_ff   <= csr_data;
            pbsp_pkg::CSR_BUDGET_LOW:    bud_low_ff     <= csr_data;
            pbsp_pkg::CSR_BUDGET_NORMAL: bud_normal_ff  <= csr_data;
            pbsp_pkg::CSR_BUDGET_HIGH:   bud_high_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign sts.align_done = pos_ff < N_R;
   assign sts.last_issue = cnt_ff == LAST_C;
   assign sts.have       = have_ff;
   assign sts.refilled   = refill_ff;

   assign found         = found_ff;
   assign chosen_slot   = chosen_ff;
   assign did_replenish = replenish_ff;

   `PBSP_ASSERT(a_eval_or_reload, !(scan_d_ff && reload_d_ff), "scan and reload overlap")
   `PBSP_ASSERT(a_write_alone, !(slot_wr && (scan_d_ff || reload_d_ff)), "slot write during scan")

endmodule

// ===== src/pbsp_controller.sv =====
`timescale 1ns / 1ps
`include "priority_budget_slot_picker_defines.svh"

module pbsp_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_is_pick,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pbsp_pkg::pbsp_cmd_type cmd,
   input  pbsp_pkg::pbsp_sts_type sts
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_WRITE  = 9'b000000010,
      ST_ALIGN  = 9'b000000100,
      ST_SCAN   = 9'b000001000,
      ST_SDRAIN = 9'b000010000,
      ST_DECIDE = 9'b000100000,
      ST_RELOAD = 9'b001000000,
      ST_RDRAIN = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Sequence one request through the datapath
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = req_is_pick ? ST_ALIGN : ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.slot_write = 1'b1;
            state_in       = ST_DONE;
         end
         ST_ALIGN: begin
            cmd.align_step = 1'b1;
            if (sts.align_done) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (sts.last_issue) begin
               state_in = ST_SDRAIN;
            end
         end
         ST_SDRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = (sts.have || sts.refilled) ? ST_DONE : ST_RELOAD;
         end
         ST_RELOAD: begin
            cmd.reload_rd = 1'b1;
            if (sts.last_issue) begin
               state_in = ST_RDRAIN;
            end
         end
         ST_RDRAIN: begin
            state_in = ST_SCAN;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the response until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `PBSP_ASSERT_NEXT(a_finish_shows, cmd.finish, rsp_valid_ff, "finished request not shown")
   `PBSP_ASSERT_NEXT(a_accept_busy, accept, !req_ready, "request taken while busy")
   `PBSP_ASSERT(a_one_reload, $rose(state_ff == ST_RELOAD) |-> !sts.refilled, "second reload")

endmodule
